[design/slx_pkg.sv]
// Shared types, character constants and token codes for the character stream lexer.
package slx_pkg;

  localparam int LINE_OUT_W   = 20;
  localparam int COLUMN_OUT_W = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_SLASH      = 8'h2F;
  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_RETURN     = 8'h0D;

  typedef enum logic [2:0] {
    KIND_BEGIN    = 3'd0,
    KIND_CONT     = 3'd1,
    KIND_END_NAME = 3'd2,
    KIND_PUNCT    = 3'd3,
    KIND_EOF      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t                   token_kind;
    logic [7:0]              token_char;
    logic [LINE_OUT_W-1:0]   at_line;
    logic [COLUMN_OUT_W-1:0] at_column;
    logic                    last_of_run;
  } out_item_t;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              ch;
    logic [LINE_OUT_W-1:0]   line;
    logic [COLUMN_OUT_W-1:0] column;
  } rec_t;

  typedef struct packed {
    logic two;
    rec_t first;
    rec_t second;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_entry_t;

  function automatic out_item_t to_out(rec_t r, logic last);
    out_item_t o;
    o.token_kind  = r.kind;
    o.token_char  = r.ch;
    o.at_line     = r.line;
    o.at_column   = r.column;
    o.last_of_run = last;
    return o;
  endfunction

endpackage

[design/char_stream_lexer.sv]
// Top level of the character stream lexer: front end, job queue and result sequencer.
// Usage: one source character per item enters on the char channel (char_valid,
// char_stall, char_item with byte_in and end_of_input). Token events leave on the
// token channel (token_valid, token_stall, token_item) in source order; the last
// event caused by a character carries last_of_run.
// With an empty queue, the first result of a character is written into a queue
// slot when the character is accepted and moves from there into the output register,
// so the earliest result handshake follows the input handshake through both registers.
// Throughput: one character per cycle while each causes at most one token and
// token_stall stays low; a character that causes two tokens holds the single output
// register for both in turn. Characters that cause no token never reach the output.
// Reset clears the scanner state, sets line and column to 1, empties the
// four-entry job queue and drops token_valid.
// When the receiver stalls, the output holds its item, the queue fills with
// pending jobs, and char_stall rises once all four entries are occupied.
module char_stream_lexer #(
  parameter int LINE_WIDTH   = 20,
  parameter int COLUMN_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  slx_pkg::in_item_t  char_item,
  output logic               token_valid,
  input  logic               token_stall,
  output slx_pkg::out_item_t token_item
);

  slx_pkg::q_entry_t push, head;
  logic              queue_full, pop;

  slx_front #(
    .LINE_WIDTH  (LINE_WIDTH),
    .COLUMN_WIDTH(COLUMN_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_item (char_item),
    .queue_full(queue_full),
    .push      (push)
  );

  slx_queue u_queue (
    .clk (clk),
    .rst (rst),
    .push(push),
    .full(queue_full),
    .pop (pop),
    .head(head)
  );

  slx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_item (token_item)
  );

endmodule

[design/slx_front.sv]
// Scanner front end: accepts characters, tracks position and lexer state, builds result jobs.
module slx_front #(
  parameter int LINE_WIDTH   = 20,
  parameter int COLUMN_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  slx_pkg::in_item_t  char_item,
  input  logic               queue_full,
  output slx_pkg::q_entry_t  push
);

  logic                    in_comment, in_comment_next;
  logic                    in_name, in_name_next;
  logic                    slash_held, slash_held_next;
  logic [LINE_WIDTH-1:0]   held_line, held_line_next;
  logic [COLUMN_WIDTH-1:0] held_column, held_column_next;
  logic [LINE_WIDTH-1:0]   line_count, line_count_next;
  logic [COLUMN_WIDTH-1:0] column_count, column_count_next;

  logic       accept;
  logic [7:0] c;
  logic       is_space, is_name, is_slash, is_newline;
  logic       f_emit;
  slx_pkg::rec_t f_rec, cur_eof, held_punct;
  slx_pkg::rec_t rec_first, rec_second;
  logic [1:0]    n_out;

  function automatic slx_pkg::rec_t make_rec(slx_pkg::kind_t k, logic [7:0] ch,
                                             logic [LINE_WIDTH-1:0] l,
                                             logic [COLUMN_WIDTH-1:0] col);
    slx_pkg::rec_t r;
    logic [slx_pkg::LINE_OUT_W+LINE_WIDTH-1:0]     l_ext;
    logic [slx_pkg::COLUMN_OUT_W+COLUMN_WIDTH-1:0] c_ext;
    l_ext    = {{slx_pkg::LINE_OUT_W{1'b0}}, l};
    c_ext    = {{slx_pkg::COLUMN_OUT_W{1'b0}}, col};
    r.kind   = k;
    r.ch     = ch;
    r.line   = l_ext[slx_pkg::LINE_OUT_W-1:0];
    r.column = c_ext[slx_pkg::COLUMN_OUT_W-1:0];
    return r;
  endfunction

  assign c          = char_item.byte_in;
  assign accept     = char_valid && !queue_full;
  assign char_stall = queue_full;

  assign is_space   = (c == slx_pkg::CHAR_SPACE) ||
                      ((c >= slx_pkg::CHAR_TAB) && (c <= slx_pkg::CHAR_RETURN));
  assign is_name    = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                      ((c >= 8'h30) && (c <= 8'h39)) || (c == slx_pkg::CHAR_UNDERSCORE);
  assign is_slash   = (c == slx_pkg::CHAR_SLASH);
  assign is_newline = (c == slx_pkg::CHAR_NEWLINE);

  assign f_emit     = !is_space && !is_slash;
  assign f_rec      = make_rec(is_name ? slx_pkg::KIND_BEGIN : slx_pkg::KIND_PUNCT, c,
                               line_count, column_count);
  assign cur_eof    = make_rec(slx_pkg::KIND_EOF, 8'h00, line_count, column_count);
  assign held_punct = make_rec(slx_pkg::KIND_PUNCT, slx_pkg::CHAR_SLASH,
                               held_line, held_column);

  always_comb begin
    in_comment_next   = in_comment;
    in_name_next      = in_name;
    slash_held_next   = slash_held;
    held_line_next    = held_line;
    held_column_next  = held_column;
    line_count_next   = line_count;
    column_count_next = column_count;
    rec_first         = f_rec;
    rec_second        = f_rec;
    n_out             = 2'd0;

    if (char_item.end_of_input) begin
      if (in_name) begin
        rec_first = make_rec(slx_pkg::KIND_END_NAME, 8'h00, line_count, column_count);
        rec_second = cur_eof;
        n_out = 2'd2;
      end else if (slash_held) begin
        rec_first = held_punct;
        rec_second = cur_eof;
        n_out = 2'd2;
      end else begin
        rec_first = cur_eof;
        n_out = 2'd1;
      end
      in_comment_next   = 1'b0;
      in_name_next      = 1'b0;
      slash_held_next   = 1'b0;
      held_line_next    = LINE_WIDTH'(1);
      held_column_next  = COLUMN_WIDTH'(1);
      line_count_next   = LINE_WIDTH'(1);
      column_count_next = COLUMN_WIDTH'(1);
    end else begin
      if (in_comment) begin
        if (is_newline) begin
          in_comment_next = 1'b0;
        end
      end else if (slash_held) begin
        slash_held_next = 1'b0;
        if (is_slash) begin
          in_comment_next = 1'b1;
        end else begin
          rec_first = held_punct;
          rec_second = f_rec;
          n_out = f_emit ? 2'd2 : 2'd1;
          in_name_next = is_name;
        end
      end else if (in_name) begin
        if (is_name) begin
          rec_first = make_rec(slx_pkg::KIND_CONT, c, line_count, column_count);
          n_out = 2'd1;
        end else begin
          rec_first = make_rec(slx_pkg::KIND_END_NAME, 8'h00, line_count, column_count);
          rec_second = f_rec;
          n_out = f_emit ? 2'd2 : 2'd1;
          in_name_next = 1'b0;
          if (is_slash) begin
            slash_held_next  = 1'b1;
            held_line_next   = line_count;
            held_column_next = column_count;
          end
        end
      end else begin
        rec_first = f_rec;
        n_out = f_emit ? 2'd1 : 2'd0;
        in_name_next = is_name;
        if (is_slash) begin
          slash_held_next  = 1'b1;
          held_line_next   = line_count;
          held_column_next = column_count;
        end
      end

      if (is_newline) begin
        if (line_count != {LINE_WIDTH{1'b1}}) begin
          line_count_next = line_count + 1'b1;
        end
        column_count_next = COLUMN_WIDTH'(1);
      end else if (column_count != {COLUMN_WIDTH{1'b1}}) begin
        column_count_next = column_count + 1'b1;
      end
    end
  end

  assign push.valid      = accept && (n_out != 2'd0);
  assign push.job.two    = (n_out == 2'd2);
  assign push.job.first  = rec_first;
  assign push.job.second = rec_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_comment   <= 1'b0;
      in_name      <= 1'b0;
      slash_held   <= 1'b0;
      held_line    <= LINE_WIDTH'(1);
      held_column  <= COLUMN_WIDTH'(1);
      line_count   <= LINE_WIDTH'(1);
      column_count <= COLUMN_WIDTH'(1);
    end else if (accept) begin
      in_comment   <= in_comment_next;
      in_name      <= in_name_next;
      slash_held   <= slash_held_next;
      held_line    <= held_line_next;
      held_column  <= held_column_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
    end
  end

endmodule

[design/slx_queue.sv]
// Short job queue between the scanner front end and the result sequencer.
module slx_queue (
  input  logic              clk,
  input  logic              rst,
  input  slx_pkg::q_entry_t push,
  output logic              full,
  input  logic              pop,
  output slx_pkg::q_entry_t head
);

  slx_pkg::job_t                 slots [slx_pkg::QUEUE_DEPTH];
  logic [slx_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [slx_pkg::QUEUE_CNT_W-1:0] count;
  logic                            do_push, do_pop;

  assign full       = (count == slx_pkg::QUEUE_CNT_W'(slx_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full) else $error("job pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= slx_pkg::QUEUE_CNT_W'(slx_pkg::QUEUE_DEPTH)) else $error("queue count overflow");

endmodule

[design/slx_back.sv]
// Result sequencer: unpacks queued jobs into single token items behind an output register.
module slx_back (
  input  logic               clk,
  input  logic               rst,
  input  slx_pkg::q_entry_t  head,
  output logic               pop,
  output logic               token_valid,
  input  logic               token_stall,
  output slx_pkg::out_item_t token_item
);

  logic          load;
  logic          sec_valid;
  slx_pkg::rec_t sec_rec;

  assign load = !token_valid || !token_stall;
  assign pop  = load && !sec_valid && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      sec_valid   <= 1'b0;
    end else if (load) begin
      if (sec_valid) begin
        token_item  <= slx_pkg::to_out(sec_rec, 1'b1);
        token_valid <= 1'b1;
        sec_valid   <= 1'b0;
      end else if (head.valid) begin
        token_item  <= slx_pkg::to_out(head.job.first, !head.job.two);
        token_valid <= 1'b1;
        sec_rec     <= head.job.second;
        sec_valid   <= head.job.two;
      end else begin
        token_valid <= 1'b0;
      end
    end
  end

  a_second_pending: assert property (@(posedge clk) disable iff (rst)
    sec_valid == (token_valid && !token_item.last_of_run))
    else $error("pending second result out of step with output register");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid) else $error("pop from an empty queue");

endmodule
